// ===== hdl/odwc_pkg.sv =====
// Shared types and constants for the omni drive wheel commander.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package odwc_pkg;

    localparam int WHEEL_COUNT   = 3;
    localparam int MAX_DUTY_BITS = 14;
    localparam int DUTY_W        = 14;
    localparam int SPEED_W       = 16;
    localparam int MAX_W         = 15;
    localparam int CTR_W         = 10;
    localparam int BITS_W        = 4;
    localparam int POL_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 15;
    localparam int NUM_W         = 43;
    localparam int Q1_W          = 27;
    localparam int QV_W          = 18;
    localparam int DIVD_W        = 31;
    localparam int DIVS_W        = 16;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = 2;
    localparam int Q_CNT_W       = 3;
    localparam int HALF_SHIFT    = 15;
    localparam int RECIP_SHIFT   = 27;

    localparam logic signed [NUM_W-1:0] MIX_SCALE  = 43'sd32768000;
    localparam logic signed [NUM_W-1:0] K_SQRT3_2  = 43'sd28378000;
    localparam logic signed [NUM_W-1:0] K_STRAFE   = 43'sd22938000;
    localparam logic [NUM_W-1:0]        ROUND_HALF = 43'd16384000;
    localparam logic [QV_W-1:0]         RECIP_1000 = 18'd134217;
    localparam logic [Q1_W:0]           MM_DIVISOR = 28'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 3'd4;

    localparam logic [1:0] OP_SET_VEL   = 2'd0;
    localparam logic [1:0] OP_SET_WHEEL = 2'd1;
    localparam logic [1:0] OP_STRAFE    = 2'd2;
    localparam logic [1:0] OP_STOP      = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DISABLED  = 2'd1;
    localparam logic [1:0] ST_BAD_WHEEL = 2'd2;

    localparam logic [1:0] WHEEL_FIRST  = 2'd0;
    localparam logic [1:0] WHEEL_MID    = 2'd1;
    localparam logic [1:0] WHEEL_LAST   = 2'd2;
    localparam logic [1:0] WHEEL_NONE   = 2'd3;

    typedef struct packed {
        logic                  enabled;
        logic [CTR_W-1:0]      centre_to_wheel_mm;
        logic [MAX_W-1:0]      max_speed_mm_s;
        logic [BITS_W-1:0]     duty_bits;
        logic [POL_W-1:0]      polarity_reversed;
    } cfg_t;

    // One wheel job: the exact mix numerator, scaled by MIX_SCALE.
    typedef struct packed {
        logic [NUM_W-1:0]      num;
        logic [1:0]            wheel;
        logic [1:0]            status;
        logic                  last;
    } task_t;

    typedef struct packed {
        logic [1:0]            wheel;
        logic                  dir_a;
        logic                  dir_b;
        logic [1:0]            status;
        logic                  last;
    } pay_t;

endpackage

`default_nettype wire

// ===== hdl/odwc_front.sv =====
// Front end: accepts motion commands and splits each into wheel jobs.
// Depends on odwc_pkg; feeds odwc_queue.
`default_nettype none

module odwc_front
    import odwc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [SPEED_W-1:0] vel_x,
    input  wire logic [SPEED_W-1:0] vel_y,
    input  wire logic [SPEED_W-1:0] spin_rate,
    input  wire logic [1:0]         wheel_select,
    input  wire logic [SPEED_W-1:0] drive_speed,
    input  wire logic               q_full,
    output logic                    push,
    output task_t                   push_task
);

    logic                    busy_reg;
    logic [1:0]              idx_reg;
    logic [1:0]              last_idx_reg;
    logic [1:0]              op_reg;
    logic [1:0]              status_reg;
    logic [1:0]              wsel_reg;
    logic signed [NUM_W-1:0] tx_reg;
    logic signed [NUM_W-1:0] ty_reg;
    logic signed [NUM_W-1:0] rot_reg;

    logic                    accept;
    logic                    is_last;
    logic [1:0]              status_in;
    logic signed [NUM_W-1:0] tx_next;
    logic signed [NUM_W-1:0] ty_next;
    logic signed [NUM_W-1:0] rot_next;
    logic signed [NUM_W-1:0] half;
    logic signed [NUM_W-1:0] num;

    assign is_last  = (idx_reg == last_idx_reg);
    assign push     = busy_reg && !q_full;
    assign in_ready = !busy_reg || (push && is_last);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (!cfg.enabled)
        begin
            status_in = ST_DISABLED;
        end
        else if ((opcode == OP_SET_WHEEL) && (wheel_select == WHEEL_NONE))
        begin
            status_in = ST_BAD_WHEEL;
        end
        else
        begin
            status_in = ST_OK;
        end

        if (opcode == OP_SET_VEL)
        begin
            tx_next  = NUM_W'($signed(vel_x)) * MIX_SCALE;
            ty_next  = NUM_W'($signed(vel_y)) * K_SQRT3_2;
            rot_next = (NUM_W'($signed({1'b0, cfg.centre_to_wheel_mm}))
                        * NUM_W'($signed(spin_rate))) <<< HALF_SHIFT;
        end
        else
        begin
            tx_next  = NUM_W'($signed(drive_speed)) * MIX_SCALE;
            ty_next  = NUM_W'($signed(drive_speed)) * K_STRAFE;
            rot_next = '0;
        end
    end

    always_comb
    begin
        half = tx_reg >>> 1;
        unique case (op_reg)
            OP_SET_VEL:
            begin
                if (idx_reg == WHEEL_FIRST)
                begin
                    num = tx_reg + rot_reg;
                end
                else if (idx_reg == WHEEL_MID)
                begin
                    num = rot_reg - half - ty_reg;
                end
                else
                begin
                    num = rot_reg - half + ty_reg;
                end
            end
            OP_SET_WHEEL:
            begin
                num = tx_reg;
            end
            OP_STRAFE:
            begin
                num = (idx_reg == WHEEL_FIRST) ? -tx_reg : ty_reg;
            end
            OP_STOP:
            begin
                num = '0;
            end
        endcase

        push_task.status = status_reg;
        push_task.last   = is_last;
        if (status_reg != ST_OK)
        begin
            push_task.num   = '0;
            push_task.wheel = WHEEL_FIRST;
        end
        else
        begin
            push_task.num   = num;
            push_task.wheel = (op_reg == OP_SET_WHEEL) ? wsel_reg : idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= WHEEL_FIRST;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= WHEEL_FIRST;
        end
        else if (push)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            status_reg <= status_in;
            wsel_reg   <= wheel_select;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            rot_reg    <= rot_next;
            if ((status_in != ST_OK) || (opcode == OP_SET_WHEEL))
            begin
                last_idx_reg <= WHEEL_FIRST;
            end
            else
            begin
                last_idx_reg <= WHEEL_LAST;
            end
        end
    end

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("front not busy after taking a command");
    a_hold_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !push |=> busy_reg && $stable(idx_reg))
        else $error("front lost its place while the queue was full");
`endif

endmodule

`default_nettype wire

// ===== hdl/odwc_queue.sv =====
// Short queue of wheel jobs between the front end and the back end.
// Depends on odwc_pkg.
`default_nettype none

module odwc_queue
    import odwc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire task_t push_task,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output task_t      head_task
);

    task_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_task  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("job queue written while full");
`endif

endmodule

`default_nettype wire

// ===== hdl/odwc_div.sv =====
// Pipelined restoring divider for the PWM duty, one quotient bit per stage.
// Depends on odwc_pkg; used by odwc_back.
`default_nettype none

module odwc_div
    import odwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    input  wire pay_t              in_pay,
    output logic                   out_valid,
    output logic [DUTY_W-1:0]      quotient,
    output pay_t                   out_pay
);

    logic [DUTY_W-1:0] vld_reg;
    logic [DIVD_W-1:0] rem_reg  [DUTY_W];
    logic [DUTY_W-1:0] quo_reg  [DUTY_W];
    pay_t              pay_reg  [DUTY_W];

    logic [DIVD_W-1:0] rem_src  [DUTY_W];
    logic [DUTY_W-1:0] quo_src  [DUTY_W];
    logic [DIVD_W-1:0] sub_val  [DUTY_W];
    logic [DIVD_W-1:0] rem_next [DUTY_W];
    logic [DUTY_W-1:0] quo_next [DUTY_W];
    logic [DUTY_W-1:0] ge;

    always_comb
    begin
        rem_src[0] = dividend;
        quo_src[0] = '0;
        for (int j = 1; j < DUTY_W; j++)
        begin
            rem_src[j] = rem_reg[j-1];
            quo_src[j] = quo_reg[j-1];
        end
        for (int j = 0; j < DUTY_W; j++)
        begin
            sub_val[j]  = DIVD_W'(divisor) << (DUTY_W - 1 - j);
            ge[j]       = (rem_src[j] >= sub_val[j]);
            rem_next[j] = ge[j] ? (rem_src[j] - sub_val[j]) : rem_src[j];
            quo_next[j] = quo_src[j] | (DUTY_W'(ge[j]) << (DUTY_W - 1 - j));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DUTY_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= in_pay;
            for (int j = 1; j < DUTY_W; j++)
            begin
                pay_reg[j] <= pay_reg[j-1];
            end
            for (int j = 0; j < DUTY_W; j++)
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign out_valid = vld_reg[DUTY_W-1];
    assign quotient  = quo_reg[DUTY_W-1];
    assign out_pay   = pay_reg[DUTY_W-1];

endmodule

`default_nettype wire

// ===== hdl/odwc_back.sv =====
// Back end: rounds each wheel job to mm/s, clamps it, sets the bridge bits
// and scales the duty. Depends on odwc_pkg and odwc_div.
`default_nettype none

module odwc_back
    import odwc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   q_valid,
    input  wire task_t  q_task,
    output logic        q_pop,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output logic [23:0] m_tdata,   // wheel_id[1:0], dir_a, dir_b, duty[13:0], zero fill
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    typedef struct packed {
        logic [1:0] wheel;
        logic       neg;
        logic [1:0] status;
        logic       last;
    } meta_t;

    logic                  en;
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    meta_t                 m1_reg, m2_reg, m3_reg;
    pay_t                  p4_reg, p5_reg;
    logic [Q1_W-1:0]       q1_reg, q1b_reg;
    logic [QV_W-1:0]       qe_reg, q3_reg;
    logic [MAX_W+DUTY_W-1:0] prod4_reg;
    logic [DIVD_W-1:0]     divd_reg;

    logic                  neg_in;
    logic [NUM_W-1:0]      mag_in;
    logic [NUM_W-1:0]      rnd_in;
    logic [Q1_W+QV_W-1:0]  prod2;
    logic [Q1_W:0]         rem3;
    logic [QV_W-1:0]       q3_next;
    logic [MAX_W-1:0]      maxv;
    logic [BITS_W-1:0]     bits_eff;
    logic [DUTY_W:0]       one_sh;
    logic [DUTY_W:0]       full_ext;
    logic [DUTY_W-1:0]     full;
    logic [MAX_W-1:0]      mag_c;
    logic                  zero;
    logic                  pol_bit;
    logic                  pos;
    pay_t                  p4_next;
    logic                  d_valid;
    logic [DUTY_W-1:0]     d_duty;
    pay_t                  d_pay;

    assign en    = !d_valid || m_tready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        neg_in = q_task.num[NUM_W-1];
        mag_in = neg_in ? (~q_task.num + 1'b1) : q_task.num;
        rnd_in = mag_in + ROUND_HALF;

        prod2  = (Q1_W+QV_W)'(q1_reg) * (Q1_W+QV_W)'(RECIP_1000);

        rem3    = {1'b0, q1b_reg} - ((Q1_W+1)'(qe_reg) * MM_DIVISOR);
        q3_next = (rem3 >= MM_DIVISOR) ? (qe_reg + 1'b1) : qe_reg;

        maxv = (cfg.max_speed_mm_s == '0) ? MAX_W'(1) : cfg.max_speed_mm_s;
        if (cfg.duty_bits == '0)
        begin
            bits_eff = BITS_W'(1);
        end
        else if (cfg.duty_bits > BITS_W'(MAX_DUTY_BITS))
        begin
            bits_eff = BITS_W'(MAX_DUTY_BITS);
        end
        else
        begin
            bits_eff = cfg.duty_bits;
        end
        one_sh   = (DUTY_W+1)'(1) << bits_eff;
        full_ext = one_sh - (DUTY_W+1)'(1);
        full     = full_ext[DUTY_W-1:0];

        mag_c = (q3_reg > QV_W'(maxv)) ? maxv : q3_reg[MAX_W-1:0];
        zero  = (mag_c == '0);
        unique case (m3_reg.wheel)
            WHEEL_FIRST: pol_bit = cfg.polarity_reversed[0];
            WHEEL_MID:   pol_bit = cfg.polarity_reversed[1];
            WHEEL_LAST:  pol_bit = cfg.polarity_reversed[2];
            WHEEL_NONE:  pol_bit = 1'b0;
        endcase
        pos = !m3_reg.neg ^ pol_bit;

        p4_next.wheel  = m3_reg.wheel;
        p4_next.dir_a  = !zero && pos;
        p4_next.dir_b  = !zero && !pos;
        p4_next.status = m3_reg.status;
        p4_next.last   = m3_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg       <= rnd_in[HALF_SHIFT +: Q1_W];
            m1_reg.wheel <= q_task.wheel;
            m1_reg.neg   <= neg_in;
            m1_reg.status <= q_task.status;
            m1_reg.last  <= q_task.last;

            qe_reg  <= prod2[RECIP_SHIFT +: QV_W];
            q1b_reg <= q1_reg;
            m2_reg  <= m1_reg;

            q3_reg  <= q3_next;
            m3_reg  <= m2_reg;

            prod4_reg <= (MAX_W+DUTY_W)'(mag_c) * (MAX_W+DUTY_W)'(full);
            p4_reg    <= p4_next;

            divd_reg <= {1'b0, prod4_reg, 1'b0} + DIVD_W'(maxv);
            p5_reg   <= p4_reg;
        end
    end

    odwc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .dividend  (divd_reg),
        .divisor   ({maxv, 1'b0}),
        .in_pay    (p5_reg),
        .out_valid (d_valid),
        .quotient  (d_duty),
        .out_pay   (d_pay)
    );

    assign m_tvalid = d_valid;
    assign m_tdata  = {6'b0, d_duty, d_pay.dir_b, d_pay.dir_a, d_pay.wheel};
    assign m_tuser  = d_pay.status;
    assign m_tlast  = d_pay.last;

`ifndef ASSERT_OFF
    a_error_idle: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid && (d_pay.status != ST_OK)
        |-> (d_duty == '0) && !d_pay.dir_a && !d_pay.dir_b && (d_pay.wheel == WHEEL_FIRST))
        else $error("error result carries a drive command");
    a_bridge_safe: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> !(d_pay.dir_a && d_pay.dir_b) && ((d_duty == '0) || d_pay.dir_a || d_pay.dir_b))
        else $error("bridge inputs inconsistent with duty");
`endif

endmodule

`default_nettype wire

// ===== hdl/omni_drive_wheel_commander.sv =====
// Three-wheel omni drive commander: takes motion commands, gives one drive item per wheel.
// A command gives three wheel results, or one for a set-wheel or refused command; the
// back end takes one job per cycle while the output is not stalled. Each result passes
// through 5 rounding and scaling stages and a 14-stage duty divider after the job queue.
// Reset (rst_n, asynchronous, active low) empties the job queue and pipeline and loads
// the register defaults; there is no clearing pass.
`default_nettype none

module omni_drive_wheel_commander
    import odwc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [71:0]           s_tdata,  // vel_x, vel_y, spin_rate, wheel_select,
                                                 // drive_speed, zero fill
    input  wire logic [1:0]            s_tuser,  // opcode[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,  // wheel_id[1:0], dir_a, dir_b, duty[13:0],
                                                 // zero fill
    output logic [1:0]                 m_tuser,  // status[1:0]
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_full;
    logic  push;
    task_t push_task;
    logic  q_pop;
    logic  q_valid;
    task_t q_task;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled            <= 1'b0;
            cfg_reg.centre_to_wheel_mm <= CTR_W'(100);
            cfg_reg.max_speed_mm_s     <= MAX_W'(1000);
            cfg_reg.duty_bits          <= BITS_W'(10);
            cfg_reg.polarity_reversed  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLED:  cfg_reg.enabled            <= cfg_data[0];
                CFG_CENTRE:   cfg_reg.centre_to_wheel_mm <= cfg_data[CTR_W-1:0];
                CFG_MAX_SPD:  cfg_reg.max_speed_mm_s     <= cfg_data[MAX_W-1:0];
                CFG_DUTY_BIT: cfg_reg.duty_bits          <= cfg_data[BITS_W-1:0];
                CFG_POLARITY: cfg_reg.polarity_reversed  <= cfg_data[POL_W-1:0];
                default:      cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    odwc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .opcode       (s_tuser),
        .vel_x        (s_tdata[15:0]),
        .vel_y        (s_tdata[31:16]),
        .spin_rate    (s_tdata[47:32]),
        .wheel_select (s_tdata[49:48]),
        .drive_speed  (s_tdata[65:50]),
        .q_full       (q_full),
        .push         (push),
        .push_task    (push_task)
    );

    odwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_task  (push_task),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_task  (q_task)
    );

    odwc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_task   (q_task),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/tb_omni_drive_wheel_commander.sv =====
// Self-checking bench for the omni drive wheel commander: predicts every wheel drive item
// from the motion commands sent in and compares it with what the block produces.
// Depends on odwc_pkg and omni_drive_wheel_commander only.
module tb_omni_drive_wheel_commander
    import odwc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MIX_DEN        = 32768000;
    localparam longint SQRT3_HALF_Q15 = 28378;
    localparam longint STRAFE_Q15     = 22938;
    localparam longint Q15_ONE        = 32768;
    localparam int     CYCLE_LIMIT    = 400000;
    localparam int     HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] spin;
        logic [1:0]         sel;
        logic signed [15:0] speed;
    } motion_cmd_t;

    typedef struct packed {
        logic [1:0]  wheel;
        logic        dir_a;
        logic        dir_b;
        logic [13:0] duty;
        logic [1:0]  status;
        logic        last;
    } drive_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [71:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  cfg_en;
    logic [CTR_W-1:0]      cfg_centre;
    logic [MAX_W-1:0]      cfg_max;
    logic [BITS_W-1:0]     cfg_bits;
    logic [POL_W-1:0]      cfg_pol;
    logic [13:0]           wheel_duty_now [WHEEL_COUNT];
    logic [1:0]            wheel_dir_now [WHEEL_COUNT];

    motion_cmd_t pending_cmds [$];
    drive_cmd_t  drive_due [$];
    int          cmds_queued;
    int          cmds_taken;
    int          mismatch_count;
    int          cycle_count;
    bit          in_taken;
    int          src_gap;
    int          snk_left;
    int          hold_left;
    bit          hold_req;
    bit          src_gaps_on;
    bit          snk_gaps_on;

    omni_drive_wheel_commander DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint round_div(longint n, longint d);
        if (n >= 0)
        begin
            return (n + d / 2) / d;
        end
        return -((-n + d / 2) / d);
    endfunction

    function automatic drive_cmd_t wheel_drive(int w, longint v);
        longint     maxv;
        longint     full;
        longint     mag;
        longint     duty;
        int         bits;
        logic       pos;
        drive_cmd_t r;
        maxv = (cfg_max == 0) ? 1 : longint'(cfg_max);
        bits = int'(cfg_bits);
        if (bits < 1)
        begin
            bits = 1;
        end
        if (bits > MAX_DUTY_BITS)
        begin
            bits = MAX_DUTY_BITS;
        end
        full = (longint'(1) << bits) - 1;
        if (v > maxv)
        begin
            v = maxv;
        end
        if (v < -maxv)
        begin
            v = -maxv;
        end
        r = '0;
        r.wheel = 2'(w);
        r.status = ST_OK;
        if (v != 0)
        begin
            pos = (v > 0) ^ cfg_pol[w];
            r.dir_a = pos;
            r.dir_b = !pos;
            mag = (v < 0) ? -v : v;
            duty = (mag * full * 2 + maxv) / (maxv * 2);
            r.duty = duty[13:0];
        end
        wheel_duty_now[w] = r.duty;
        wheel_dir_now[w] = {r.dir_b, r.dir_a};
        return r;
    endfunction

    function automatic void plan_wheel_drives(motion_cmd_t c);
        drive_cmd_t r [3];
        int         n;
        longint     vx;
        longint     vy;
        longint     rot;
        longint     ky;
        longint     half;
        longint     s;
        longint     side;
        n = 3;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = '0;
        end
        if (!cfg_en)
        begin
            r[0].status = ST_DISABLED;
            n = 1;
        end
        else if (c.op == OP_SET_VEL)
        begin
            vx = longint'($signed(c.vx));
            vy = longint'($signed(c.vy));
            rot = longint'(cfg_centre) * longint'($signed(c.spin)) * Q15_ONE;
            ky = SQRT3_HALF_Q15 * vy * 1000;
            half = -vx * (MIX_DEN / 2);
            r[0] = wheel_drive(0, round_div(vx * MIX_DEN + rot, MIX_DEN));
            r[1] = wheel_drive(1, round_div(half - ky + rot, MIX_DEN));
            r[2] = wheel_drive(2, round_div(half + ky + rot, MIX_DEN));
        end
        else if (c.op == OP_SET_WHEEL)
        begin
            n = 1;
            if (c.sel == WHEEL_NONE)
            begin
                r[0].status = ST_BAD_WHEEL;
            end
            else
            begin
                r[0] = wheel_drive(int'(c.sel), longint'($signed(c.speed)));
            end
        end
        else if (c.op == OP_STRAFE)
        begin
            s = longint'($signed(c.speed));
            side = round_div(s * STRAFE_Q15, Q15_ONE);
            r[0] = wheel_drive(0, -s);
            r[1] = wheel_drive(1, side);
            r[2] = wheel_drive(2, side);
        end
        else
        begin
            for (int w = 0; w < 3; w++)
            begin
                r[w] = wheel_drive(w, 0);
            end
        end
        r[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            drive_due.push_back(r[i]);
        end
    endfunction

    function automatic int pick_gap(bit on);
        int r;
        if (!on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic logic signed [15:0] rand_speed();
        int v;
        int lim;
        case ($urandom_range(0, 3))
            0:
            begin
                return 16'($urandom);
            end
            1:
            begin
                lim = int'(cfg_max) + 2;
                if (lim > 32767)
                begin
                    lim = 32767;
                end
                v = $urandom_range(0, lim);
                return 16'($urandom_range(0, 1) ? -v : v);
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sd1;
                    3: return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 40);
                return 16'($urandom_range(0, 1) ? -v : v);
            end
        endcase
    endfunction

    function automatic motion_cmd_t rand_cmd();
        motion_cmd_t c;
        c.op = 2'($urandom_range(0, 3));
        c.vx = rand_speed();
        c.vy = rand_speed();
        c.spin = rand_speed();
        c.sel = 2'($urandom_range(0, 3));
        c.speed = rand_speed();
        return c;
    endfunction

    function automatic motion_cmd_t mk_cmd(logic [1:0] op, int vx, int vy, int spin,
                                           logic [1:0] sel, int speed);
        motion_cmd_t c;
        c.op = op;
        c.vx = 16'(vx);
        c.vy = 16'(vy);
        c.spin = 16'(spin);
        c.sel = sel;
        c.speed = 16'(speed);
        return c;
    endfunction

    task automatic queue_cmd(motion_cmd_t c);
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            queue_cmd(rand_cmd());
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (cmds_taken != cmds_queued || drive_due.size() != 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLED:  cfg_en = val[0];
            CFG_CENTRE:   cfg_centre = val[CTR_W-1:0];
            CFG_MAX_SPD:  cfg_max = val[MAX_W-1:0];
            CFG_DUTY_BIT: cfg_bits = val[BITS_W-1:0];
            CFG_POLARITY: cfg_pol = val[POL_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic set_chassis(int centre, int maxs, int bits, int pol);
        write_reg(CFG_CENTRE, 15'(centre));
        write_reg(CFG_MAX_SPD, 15'(maxs));
        write_reg(CFG_DUTY_BIT, 15'(bits));
        write_reg(CFG_POLARITY, 15'(pol));
    endtask

    // Sender: holds an item until it is taken, then waits out a random gap.
    always @(negedge clk)
    begin
        motion_cmd_t nd;
        if (!(s_tvalid && !in_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                nd = pending_cmds.pop_front();
                s_tdata <= {6'b0, nd.speed, nd.sel, nd.spin, nd.vy, nd.vx};
                s_tuser <= nd.op;
                s_tvalid <= 1'b1;
                src_gap = pick_gap(src_gaps_on);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (snk_left > 0)
        begin
            snk_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            snk_left = pick_gap(snk_gaps_on);
            m_tready <= (snk_left == 0);
        end
    end

    always @(posedge clk)
    begin
        drive_cmd_t  got;
        drive_cmd_t  want;
        motion_cmd_t c;
        if (m_tvalid && m_tready)
        begin
            got.wheel = m_tdata[1:0];
            got.dir_a = m_tdata[2];
            got.dir_b = m_tdata[3];
            got.duty = m_tdata[17:4];
            got.status = m_tuser;
            got.last = m_tlast;
            if (drive_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected drive item: wheel=%0d a=%0b b=%0b duty=%0d st=%0d last=%0b",
                             got.wheel, got.dir_a, got.dir_b, got.duty, got.status, got.last);
                end
            end
            else
            begin
                want = drive_due.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("drive item mismatch at %0t", $realtime);
                        $display("  exp wheel=%0d a=%0b b=%0b duty=%0d st=%0d last=%0b",
                                 want.wheel, want.dir_a, want.dir_b, want.duty,
                                 want.status, want.last);
                        $display("  got wheel=%0d a=%0b b=%0b duty=%0d st=%0d last=%0b",
                                 got.wheel, got.dir_a, got.dir_b, got.duty,
                                 got.status, got.last);
                    end
                end
            end
        end
        in_taken = s_tvalid && s_tready;
        if (in_taken)
        begin
            c.op = s_tuser;
            c.vx = s_tdata[15:0];
            c.vy = s_tdata[31:16];
            c.spin = s_tdata[47:32];
            c.sel = s_tdata[49:48];
            c.speed = s_tdata[65:50];
            plan_wheel_drives(c);
            cmds_taken++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_omni_drive_wheel_commander NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_en = 1'b0;
        cfg_centre = 10'd100;
        cfg_max = 15'd1000;
        cfg_bits = 4'd10;
        cfg_pol = 3'd0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            wheel_duty_now[w] = '0;
            wheel_dir_now[w] = '0;
        end
        cmds_queued = 0;
        cmds_taken = 0;
        mismatch_count = 0;
        cycle_count = 0;
        in_taken = 1'b0;
        src_gap = 0;
        snk_left = 0;
        hold_left = 0;
        hold_req = 1'b0;
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the block is not enabled: every command is refused.
        queue_cmd(mk_cmd(OP_SET_VEL, 100, 200, 300, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, 2'd1, 500));
        queue_cmd(mk_cmd(OP_STRAFE, 0, 0, 0, 2'd0, -400));
        queue_cmd(mk_cmd(OP_STOP, 0, 0, 0, 2'd3, 0));
        wait_idle();

        write_reg(CFG_ENABLED, 15'd1);
        queue_cmd(mk_cmd(OP_SET_VEL, 0, 0, 0, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 32767, 0, 0, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, -32768, 0, 0, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 0, 32767, 0, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 0, -32768, 0, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 0, 0, 32767, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 0, 0, -32768, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 300, -200, 1500, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_VEL, 1, 1, 1, 2'd0, 0));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, 2'd0, 500));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, 2'd1, -32768));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, 2'd2, 32767));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, WHEEL_NONE, 100));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, 2'd1, 0));
        queue_cmd(mk_cmd(OP_SET_WHEEL, 0, 0, 0, 2'd0, 1));
        queue_cmd(mk_cmd(OP_STRAFE, 0, 0, 0, 2'd0, 32767));
        queue_cmd(mk_cmd(OP_STRAFE, 0, 0, 0, 2'd0, -32768));
        queue_cmd(mk_cmd(OP_STRAFE, 0, 0, 0, 2'd0, 5));
        queue_cmd(mk_cmd(OP_STRAFE, 0, 0, 0, 2'd0, -5));
        queue_cmd(mk_cmd(OP_STOP, 0, 0, 0, 2'd0, 0));
        wait_idle();

        set_chassis(1000, 32767, 14, 7);
        queue_random(35);
        wait_idle();

        // Smallest settings, with both sides running flat out.
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        set_chassis(1, 1, 1, 5);
        queue_random(30);
        wait_idle();

        // Out-of-range settings and writes to unused register indexes.
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        set_chassis(0, 0, 0, 2);
        write_reg(3'd5, 15'($urandom));
        write_reg(3'd6, 15'($urandom));
        write_reg(3'd7, 15'($urandom));
        queue_random(30);
        wait_idle();

        // The receiver holds off while the sender keeps offering, so the block backs up.
        set_chassis(523, 12345, 15, 0);
        src_gaps_on = 1'b0;
        hold_req = 1'b1;
        queue_random(30);
        wait_idle();
        src_gaps_on = 1'b1;
        queue_random(10);
        wait_idle();
        queue_random(10);
        wait_idle();

        write_reg(CFG_ENABLED, 15'd0);
        queue_random(10);
        wait_idle();

        write_reg(CFG_ENABLED, 15'd1);
        for (int p = 0; p < 2; p++)
        begin
            set_chassis($urandom_range(0, 1023), $urandom_range(0, 32767),
                        $urandom_range(0, 15), $urandom_range(0, 7));
            snk_gaps_on = p[0];
            queue_random(20);
            wait_idle();
        end

        if (mismatch_count == 0 && drive_due.size() == 0)
        begin
            $display("tb_omni_drive_wheel_commander OK");
        end
        else
        begin
            $display("tb_omni_drive_wheel_commander NOT OK");
        end
        $finish;
    end

endmodule
